// ===== rtl/mfde_pkg.sv =====
// shared constants and types for the monochrome framebuffer draw engine
package mfde_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int GLYPH_SIDE        = 8;
  localparam int GLYPH_BITS        = GLYPH_SIDE * GLYPH_SIDE;

  typedef enum logic [2:0] {
    MODE_PIXEL = 3'd0,
    MODE_HLINE = 3'd1,
    MODE_VLINE = 3'd2,
    MODE_RECT  = 3'd3,
    MODE_GLYPH = 3'd4,
    MODE_CLEAR = 3'd5,
    MODE_READ  = 3'd6
  } mode_t;

endpackage

// ===== rtl/mfde_cmd_if.sv =====
// command channel: valid, ready and one drawing command per beat
interface mfde_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [7:0]  start_x;
  logic [7:0]  start_y;
  logic [7:0]  end_x;
  logic [7:0]  end_y;
  logic [7:0]  line_length;
  logic [63:0] glyph_bits;
  logic [9:0]  byte_index;

  modport source (
    output valid, mode, start_x, start_y, end_x, end_y, line_length, glyph_bits,
    byte_index,
    input  ready
  );
  modport sink (
    input  valid, mode, start_x, start_y, end_x, end_y, line_length, glyph_bits,
    byte_index,
    output ready
  );
endinterface

// ===== rtl/mfde_rsp_if.sv =====
// response channel: valid, ready and one result per beat
interface mfde_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_valid;

  modport source (output valid, read_data, read_valid, input ready);
  modport sink (input valid, read_data, read_valid, output ready);
endinterface

// ===== rtl/mono_framebuffer_draw_engine_unit.sv =====
// framebuffer draw engine top level: command sequencer, frame store and result register
//
//   channel | role   | beat carries
//   cmd     | sink   | mode, start_x, start_y, end_x, end_y, line_length, glyph_bits, byte_index
//   rsp     | source | read_data, read_valid
//
// drawing reads then writes the store port for each on-screen pixel and steps past
// skipped pixels without a write; a run end moves to the next segment or finishes.
// clear walks every byte, one per cycle (1024 at the default size), then finishes.
// after reset the same clearing pass runs with cmd.ready low, then the block idles.
// read byte is fetched in S_READ; results wait in the output register while rsp is stalled.
module mono_framebuffer_draw_engine_unit
  import mfde_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input logic         clk,
  input logic         rst,
  mfde_cmd_if.sink    cmd,
  mfde_rsp_if.source  rsp
);

  localparam int STORE_BYTES = SCREEN_WIDTH * ((SCREEN_HEIGHT + 7) / 8);
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_RUN,
    S_WRITE,
    S_READ,
    S_FINISH
  } state_t;

  state_t              state;
  logic                pending;
  mode_t               mode;
  logic [7:0]          sx;
  logic [7:0]          sy;
  logic [7:0]          ex;
  logic [7:0]          ey;
  logic [7:0]          llen;
  logic [63:0]         glyph;
  logic [9:0]          idx;
  logic [1:0]          seg;
  logic [8:0]          cnt;
  logic [ADDR_W-1:0]   clr_addr;
  logic [ADDR_W-1:0]   wr_addr;
  logic [7:0]          wr_mask;
  logic [7:0]          rdata;
  logic                rsp_valid_q;
  logic [7:0]          read_data_q;
  logic                read_valid_q;

  logic [7:0]          frame_store [STORE_BYTES];

  logic                run_horiz;
  logic [7:0]          run_bx;
  logic [7:0]          run_by;
  logic signed [9:0]   run_len;
  logic signed [9:0]   wlen;
  logic signed [9:0]   hlen;
  logic                last_seg;
  logic                run_active;
  logic                draw_en;
  logic [8:0]          px;
  logic [8:0]          py;
  logic                on_screen;
  logic [ADDR_W-1:0]   pix_addr;
  logic [7:0]          pix_mask;
  logic [15:0]         idx_wide;
  logic [ADDR_W-1:0]   idx_addr;
  logic                idx_in_range;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [7:0]          mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;

  assign wlen = $signed({2'b00, ex}) - $signed({2'b00, sx}) + 10'sd1;
  assign hlen = $signed({2'b00, ey}) - $signed({2'b00, sy});

  // current run of the command
  always_comb begin
    run_horiz = 1'b1;
    run_bx    = sx;
    run_by    = sy;
    run_len   = 10'sd0;
    unique case (mode)
      MODE_PIXEL: run_len = 10'sd1;
      MODE_HLINE: run_len = $signed({2'b00, llen});
      MODE_VLINE: begin
        run_horiz = 1'b0;
        run_len   = $signed({2'b00, llen});
      end
      MODE_RECT: begin
        unique case (seg)
          2'd0: run_len = wlen;
          2'd1: begin
            run_by  = ey;
            run_len = wlen;
          end
          2'd2: begin
            run_horiz = 1'b0;
            run_len   = hlen;
          end
          default: begin
            run_horiz = 1'b0;
            run_bx    = ex;
            run_len   = hlen;
          end
        endcase
      end
      MODE_GLYPH: run_len = 10'(GLYPH_BITS);
      default:    run_len = 10'sd0;
    endcase
  end

  assign last_seg   = (mode != MODE_RECT) || (seg == 2'd3);
  assign run_active = $signed({1'b0, cnt}) < run_len;

  always_comb begin
    if (mode == MODE_GLYPH) begin
      px      = {1'b0, sx} + 9'(cnt[2:0]);
      py      = {1'b0, sy} + 9'(cnt[5:3]);
      draw_en = glyph[cnt[5:0]];
    end else if (run_horiz) begin
      px      = {1'b0, run_bx} + cnt;
      py      = {1'b0, run_by};
      draw_en = 1'b1;
    end else begin
      px      = {1'b0, run_bx};
      py      = {1'b0, run_by} + cnt;
      draw_en = 1'b1;
    end
  end

  mfde_pix_addr #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .ADDR_W        (ADDR_W)
  ) u_pix_addr (
    .px        (px),
    .py        (py),
    .on_screen (on_screen),
    .addr      (pix_addr),
    .mask      (pix_mask)
  );

  assign idx_wide     = 16'(idx);
  assign idx_addr     = idx_wide[ADDR_W-1:0];
  assign idx_in_range = idx_wide < 16'(STORE_BYTES);

  // frame store port
  assign mem_we    = (state == S_CLEAR) || (state == S_WRITE);
  assign mem_waddr = (state == S_CLEAR) ? clr_addr : wr_addr;
  assign mem_wdata = (state == S_CLEAR) ? 8'h00 : (rdata | wr_mask);
  assign mem_raddr = (state == S_RUN) ? pix_addr : idx_addr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[mem_waddr] <= mem_wdata;
    end
    rdata <= frame_store[mem_raddr];
  end

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      pending     <= 1'b0;
      clr_addr    <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp.ready && (state != S_FINISH)) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            mode     <= mode_t'(cmd.mode);
            sx       <= cmd.start_x;
            sy       <= cmd.start_y;
            ex       <= cmd.end_x;
            ey       <= cmd.end_y;
            llen     <= cmd.line_length;
            glyph    <= cmd.glyph_bits;
            idx      <= cmd.byte_index;
            seg      <= 2'd0;
            cnt      <= '0;
            clr_addr <= '0;
            pending  <= 1'b1;
            unique case (mode_t'(cmd.mode))
              MODE_PIXEL, MODE_HLINE, MODE_VLINE, MODE_RECT, MODE_GLYPH: state <= S_RUN;
              MODE_CLEAR: state <= S_CLEAR;
              MODE_READ:  state <= S_READ;
              default:    state <= S_FINISH;
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= pending ? S_FINISH : S_IDLE;
          end
        end
        S_RUN: begin
          if (!run_active) begin
            cnt <= '0;
            if (last_seg) begin
              state <= S_FINISH;
            end else begin
              seg <= seg + 2'd1;
            end
          end else if (draw_en && on_screen) begin
            wr_addr <= pix_addr;
            wr_mask <= pix_mask;
            state   <= S_WRITE;
          end else begin
            cnt <= cnt + 9'd1;
          end
        end
        S_WRITE: begin
          cnt   <= cnt + 9'd1;
          state <= S_RUN;
        end
        S_READ: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!rsp_valid_q || rsp.ready) begin
            rsp_valid_q  <= 1'b1;
            read_data_q  <= (mode == MODE_READ && idx_in_range) ? rdata : 8'h00;
            read_valid_q <= (mode == MODE_READ);
            pending      <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign cmd.ready      = (state == S_IDLE);
  assign rsp.valid      = rsp_valid_q;
  assign rsp.read_data  = read_data_q;
  assign rsp.read_valid = read_valid_q;

endmodule

// ===== rtl/mfde_pix_addr.sv =====
// pixel address unit: screen bounds check, byte address and bit mask
module mfde_pix_addr
  import mfde_pkg::*;
#(
  parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
  parameter int ADDR_W        = 10
) (
  input  logic [8:0]        px,
  input  logic [8:0]        py,
  output logic              on_screen,
  output logic [ADDR_W-1:0] addr,
  output logic [7:0]        mask
);

  logic [15:0] addr_full;

  assign on_screen = ({1'b0, px} < 10'(SCREEN_WIDTH)) && ({1'b0, py} < 10'(SCREEN_HEIGHT));
  assign addr_full = 16'(px) + 16'(py[8:3]) * 16'(SCREEN_WIDTH);
  assign addr      = addr_full[ADDR_W-1:0];
  assign mask      = 8'h01 << py[2:0];

endmodule

// ===== rtl/mfde_checker.sv =====
// port-level checks for the framebuffer draw engine, bound to the top level
module mfde_checker (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] read_data,
  input logic       read_valid
);

  // stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> rsp_valid)
    else $error("result dropped while stalled");

  // a command keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && cmd_ready) |=> !cmd_ready)
    else $error("ready straight after an accepted beat");

  // clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !cmd_ready)
    else $error("ready during the clearing pass");

  // only read-back results carry data
  a_zero_unless_read: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !read_valid) |-> (read_data == 8'h00))
    else $error("data on a non-read result");

endmodule

bind mono_framebuffer_draw_engine_unit mfde_checker u_mfde_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .read_data  (rsp.read_data),
  .read_valid (rsp.read_valid)
);
